FILE: rtl/tmtb_pkg.sv
// ----------------------------------------------------------------------------
// tmtb_pkg
// Shared types and constants for the ping-pong tile transpose buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmtb_pkg;

  localparam int TILE_SIDE  = 32;
  localparam int TILE_ELEMS = TILE_SIDE * TILE_SIDE;
  localparam int DIM_W      = $clog2(TILE_SIDE);
  localparam int POS_W      = $clog2(TILE_ELEMS);
  localparam int MEM_DEPTH  = 2 * TILE_ELEMS;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);

  localparam int DATA_W     = 32;
  localparam int COORD_W    = 11;
  localparam int HEIGHT_W   = 17;
  localparam int ADDR_W     = 32;
  // (tile index * TILE_SIDE + offset) fits in this many bits
  localparam int BASE_W     = COORD_W + DIM_W;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(4096);

  typedef struct packed {
    logic [DATA_W-1:0]  element_value;
    logic [COORD_W-1:0] tile_col;
    logic [COORD_W-1:0] tile_row;
    logic               drain;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic [ADDR_W-1:0] out_address;
    logic              tile_last;
  } out_word_t;

endpackage : tmtb_pkg

`default_nettype wire

FILE: rtl/tiled_matrix_transpose_buffer_top.sv
// ----------------------------------------------------------------------------
// tiled_matrix_transpose_buffer_top
// Ping-pong tile transposer: stores one tile row-major, emits the other
// column-major with its linear address in the output matrix.
// ----------------------------------------------------------------------------
// Takes one word per cycle unless stalled by the output, and gives at most
// one result per word, registered in stage 1 and then in the output stage.
// Both tiles live in one 2*TILE_SIDE*TILE_SIDE x 32 memory with one write
// and one registered read port: the element arriving is written into the
// fill bank while the element leaving is read from the other bank in the
// same cycle, so the rate is set by that single read port at one element
// per cycle when the output does not stall. The output address is formed by
// one 16x17 multiply and add in the stage after the memory read. The memory
// is not cleared after reset; only fully written tiles are ever read.
// matrix_height may only be written while the block is idle.
`default_nettype none

module tiled_matrix_transpose_buffer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire tmtb_pkg::in_word_t            in_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      tmtb_pkg::out_word_t           out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [tmtb_pkg::HEIGHT_W-1:0] cfg_wdata_i
);

  localparam int DIM_W   = tmtb_pkg::DIM_W;
  localparam int POS_W   = tmtb_pkg::POS_W;
  localparam int MEM_AW  = tmtb_pkg::MEM_AW;
  localparam int COORD_W = tmtb_pkg::COORD_W;
  localparam int BASE_W  = tmtb_pkg::BASE_W;
  localparam int PROD_W  = BASE_W + tmtb_pkg::HEIGHT_W;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [tmtb_pkg::HEIGHT_W-1:0] height_q;
  logic [POS_W-1:0]              wr_pos_q;
  logic                          wr_bank_q;
  logic [2*COORD_W-1:0]          wr_coords_q;   // {row, col}
  logic                          pend_v_q;
  logic [2*COORD_W-1:0]          pend_coords_q; // {row, col}
  logic [DIM_W-1:0]              rd_r_q;
  logic [DIM_W-1:0]              rd_c_q;

  logic in_fire, emit, store, rd_last, wr_last;
  logic s1_v_q, s1_adv, out_v_q;

  assign in_fire = in_valid_i && in_ready_o;
  assign emit    = in_fire && pend_v_q;
  assign store   = in_fire && !in_data_i.drain;
  assign rd_last = (rd_r_q == DIM_W'(tmtb_pkg::TILE_SIDE - 1)) &&
                   (rd_c_q == DIM_W'(tmtb_pkg::TILE_SIDE - 1));
  assign wr_last = (wr_pos_q == POS_W'(tmtb_pkg::TILE_ELEMS - 1));

  // --------------------------------------------------------------------------
  // Tile memory: fill bank = wr_bank_q, drain bank = the other one
  // --------------------------------------------------------------------------
  logic [tmtb_pkg::DATA_W-1:0] mem [tmtb_pkg::MEM_DEPTH];
  logic [tmtb_pkg::DATA_W-1:0] rdata_q;
  logic [MEM_AW-1:0]           wr_idx, rd_idx;

  assign wr_idx = (wr_bank_q ? MEM_AW'(tmtb_pkg::TILE_ELEMS) : '0) + MEM_AW'(wr_pos_q);
  // transposed read: element (r, c) of the output tile sits at c*T + r
  assign rd_idx = (wr_bank_q ? '0 : MEM_AW'(tmtb_pkg::TILE_ELEMS))
                + MEM_AW'(rd_c_q * tmtb_pkg::TILE_SIDE) + MEM_AW'(rd_r_q);

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[wr_idx] <= in_data_i.element_value;
    end
    // held while stage 1 is stalled: only a new emit can replace it
    if (emit) begin
      rdata_q <= mem[rd_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Counters and bank control
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q      <= tmtb_pkg::HEIGHT_RESET;
      wr_pos_q      <= '0;
      wr_bank_q     <= 1'b0;
      wr_coords_q   <= '0;
      pend_v_q      <= 1'b0;
      pend_coords_q <= '0;
      rd_r_q        <= '0;
      rd_c_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
      // a completed tile takes over, even if the old one is not fully read
      if (store && wr_last) begin
        pend_v_q      <= 1'b1;
        pend_coords_q <= wr_coords_q;
        rd_r_q        <= '0;
        rd_c_q        <= '0;
      end else if (emit) begin
        if (rd_last) begin
          rd_r_q   <= '0;
          rd_c_q   <= '0;
          pend_v_q <= 1'b0;
        end else if (rd_c_q == DIM_W'(tmtb_pkg::TILE_SIDE - 1)) begin
          rd_c_q <= '0;
          rd_r_q <= rd_r_q + 1'b1;
        end else begin
          rd_c_q <= rd_c_q + 1'b1;
        end
      end
      if (store) begin
        if (wr_pos_q == '0) begin
          wr_coords_q <= {in_data_i.tile_row, in_data_i.tile_col};
        end
        if (wr_last) begin
          wr_pos_q  <= '0;
          wr_bank_q <= !wr_bank_q;
        end else begin
          wr_pos_q <= wr_pos_q + 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: address terms beside the memory read data
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] row_base, col_off;
  logic [BASE_W-1:0] s1_row_base_q, s1_col_off_q;
  logic              s1_last_q;

  assign row_base = BASE_W'(pend_coords_q[COORD_W-1:0] * tmtb_pkg::TILE_SIDE)
                  + BASE_W'(rd_r_q);
  assign col_off  = BASE_W'(pend_coords_q[2*COORD_W-1:COORD_W] * tmtb_pkg::TILE_SIDE)
                  + BASE_W'(rd_c_q);

  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_v_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_row_base_q <= row_base;
      s1_col_off_q  <= col_off;
      s1_last_q     <= rd_last;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: output register
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]             prod;
  logic [tmtb_pkg::ADDR_W-1:0]   addr;
  tmtb_pkg::out_word_t           out_q;

  assign prod = PROD_W'(s1_row_base_q) * PROD_W'(height_q);
  assign addr = prod[tmtb_pkg::ADDR_W-1:0] + tmtb_pkg::ADDR_W'(s1_col_off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || out_ready_i) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q.result_value <= rdata_q;
      out_q.out_address  <= addr;
      out_q.tile_last    <= s1_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // read data must survive a stall of stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !s1_adv |=> $stable(rdata_q))
    else $error("read data changed under a stalled stage 1");

  // input backpressure only when both stages are full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_v_q && out_v_q)
    else $error("input stalled with room in the pipeline");

  // with no tile pending the read counters rest at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_v_q |-> rd_r_q == '0 && rd_c_q == '0)
    else $error("read position moved with no tile pending");

  // a finished tile is pending and read from its start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    store && wr_last |=> pend_v_q && rd_r_q == '0 && rd_c_q == '0)
    else $error("completed tile not made pending");

  // emitting the last element on a drain word releases the tile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && rd_last && in_data_i.drain |=> !pend_v_q)
    else $error("tile still pending after its last element");
`endif

endmodule : tiled_matrix_transpose_buffer_top

`default_nettype wire
